/* src/nearest_depth_cell_match_assert.svh */
// Assertion macros for the nearest depth cell matcher checker.
// No dependencies; included by the checker file.
`ifndef NEAREST_DEPTH_CELL_MATCH_ASSERT_SVH
`define NEAREST_DEPTH_CELL_MATCH_ASSERT_SVH

// same-cycle implication
`define NDCM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ndcm check failed");

// next-cycle implication
`define NDCM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ndcm check failed");

`endif

/* src/ndcm_pkg.sv */
// Shared constants and types for the nearest depth cell matcher.
// No dependencies; used by the top level and the port checker.
`timescale 1ns / 1ps

package ndcm_pkg;

   localparam int MAX_ENTRIES = 64;
   localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

   localparam int DEPTH_W = 32;
   localparam int CELL_W  = 16;
   localparam int OUT_W   = 17;
   localparam int DIFF_W  = 33;
   localparam int TOL_W   = 31;

   localparam logic [DIFF_W-1:0] SCAN_BOUND = 33'd102400000;
   localparam logic [TOL_W-1:0]  TOL_RESET  = 31'd10240;

   localparam logic [1:0] MODE_CLEAR = 2'd0;
   localparam logic [1:0] MODE_LOAD  = 2'd1;
   localparam logic [1:0] MODE_QUERY = 2'd2;

   localparam logic [1:0] CSR_TOL_ADDR = 2'd0;

   typedef struct packed {
      logic [DEPTH_W-1:0] depth;
      logic [CELL_W-1:0]  ci;
      logic [CELL_W-1:0]  cj;
      logic [CELL_W-1:0]  ck;
   } entry_type;

endpackage

/* src/nearest_depth_cell_match.sv */
// Nearest depth cell matcher: entry table in a simple dual-port memory, one
// shared subtract/compare unit scanning it under a small sequencer.
// Depends on ndcm_pkg.
`timescale 1ns / 1ps

// Use:
//   req_* beats carry a mode: clear the table, load one entry (depth and
//   i, j, k), or query a depth. A beat is taken when req_valid is high and
//   req_stall is low.
//   Clear and load with room keep req_stall low and give no result beat.
//   A load into a full table gives one rsp_* beat with load_refused set.
//   A query reads one stored entry per cycle through the memory read port
//   and compares it in the shared difference unit, then passes through
//   the drain and decide states into the result register (an empty table
//   goes straight to decide); the next beat is taken once the sequencer is
//   back in idle.
//   req_stall is high from a query or refused load until its result sits
//   in the output register; the next beat may enter while that result
//   still waits on rsp_stall. A finished result waits in the sequencer
//   while the output register is still held by a stalled beat.
//   match_tolerance is written through the csr_ port, only while idle,
//   by the user; nothing in the block enforces it. Reset empties the table
//   (entry count zero, memory left as is), sets tolerance to 10 m and drops rsp_valid.
module nearest_depth_cell_match (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_mode,
   input  logic signed [ndcm_pkg::DEPTH_W-1:0] req_depth,
   input  logic [ndcm_pkg::CELL_W-1:0]         req_cell_i,
   input  logic [ndcm_pkg::CELL_W-1:0]         req_cell_j,
   input  logic [ndcm_pkg::CELL_W-1:0]         req_cell_k,
   input  logic                                req_last_query,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_found,
   output logic signed [ndcm_pkg::OUT_W-1:0]   rsp_out_i,
   output logic signed [ndcm_pkg::OUT_W-1:0]   rsp_out_j,
   output logic signed [ndcm_pkg::OUT_W-1:0]   rsp_out_k,
   output logic                                rsp_load_refused,
   output logic                                rsp_last_of_batch,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [1:0]                          csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_DECIDE} state_type;

   state_type                        state_ff, state_in;
   logic [ndcm_pkg::CNT_W-1:0]       count_ff, count_in;
   logic [ndcm_pkg::IDX_W-1:0]       addr_ff, addr_in;
   logic                             rd_vld_ff, rd_vld_in;
   ndcm_pkg::entry_type              rd_data_ff;
   logic [ndcm_pkg::TOL_W-1:0]       tol_ff, tol_in;
   logic [ndcm_pkg::DEPTH_W-1:0]     q_ff, q_in;
   logic                             last_ff, last_in;
   logic                             refused_ff, refused_in;
   logic [ndcm_pkg::DIFF_W-1:0]      best_ff, best_in;
   logic                             chosen_ff, chosen_in;
   logic [ndcm_pkg::CELL_W-1:0]      bi_ff, bi_in, bj_ff, bj_in, bk_ff, bk_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             found_ff, found_in;
   logic [ndcm_pkg::OUT_W-1:0]       oi_ff, oi_in, oj_ff, oj_in, ok_ff, ok_in;
   logic                             refd_ff, refd_in;
   logic                             lob_ff, lob_in;

   ndcm_pkg::entry_type              mem [ndcm_pkg::MAX_ENTRIES];
   logic                             mem_we;
   ndcm_pkg::entry_type              wr_entry;

   logic                             req_accept;
   logic                             csr_write;
   logic signed [ndcm_pkg::DIFF_W-1:0] sub;
   logic [ndcm_pkg::DIFF_W-1:0]      diff;
   logic                             scan_last;
   logic                             match;

   assign req_accept = req_valid && (state_ff == S_IDLE);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr == ndcm_pkg::CSR_TOL_ADDR);

   assign wr_entry.depth = req_depth;
   assign wr_entry.ci    = req_cell_i;
   assign wr_entry.cj    = req_cell_j;
   assign wr_entry.ck    = req_cell_k;

   // shared difference unit
   assign sub  = $signed({q_ff[ndcm_pkg::DEPTH_W-1], q_ff})
               - $signed({rd_data_ff.depth[ndcm_pkg::DEPTH_W-1], rd_data_ff.depth});
   assign diff = sub[ndcm_pkg::DIFF_W-1] ? ndcm_pkg::DIFF_W'(-sub) : ndcm_pkg::DIFF_W'(sub);

   assign scan_last = (addr_ff == ndcm_pkg::IDX_W'(count_ff - ndcm_pkg::CNT_W'(1)));
   assign match     = chosen_ff && (best_ff < {2'b00, tol_ff});

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      addr_in      = addr_ff;
      rd_vld_in    = 1'b0;
      tol_in       = tol_ff;
      q_in         = q_ff;
      last_in      = last_ff;
      refused_in   = refused_ff;
      best_in      = best_ff;
      chosen_in    = chosen_ff;
      bi_in        = bi_ff;
      bj_in        = bj_ff;
      bk_in        = bk_ff;
      rsp_valid_in = rsp_valid_ff;
      found_in     = found_ff;
      oi_in        = oi_ff;
      oj_in        = oj_ff;
      ok_in        = ok_ff;
      refd_in      = refd_ff;
      lob_in       = lob_ff;
      mem_we       = 1'b0;

      if (csr_write) begin
         tol_in = csr_pwdata[ndcm_pkg::TOL_W-1:0];
      end

      if (rd_vld_ff && (diff < best_ff)) begin
         best_in   = diff;
         chosen_in = 1'b1;
         bi_in     = rd_data_ff.ci;
         bj_in     = rd_data_ff.cj;
         bk_in     = rd_data_ff.ck;
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               case (req_mode)
                  ndcm_pkg::MODE_CLEAR: begin
                     count_in = '0;
                  end
                  ndcm_pkg::MODE_LOAD: begin
                     if (count_ff >= ndcm_pkg::CNT_W'(ndcm_pkg::MAX_ENTRIES)) begin
                        refused_in = 1'b1;
                        last_in    = 1'b0;
                        chosen_in  = 1'b0;
                        state_in   = S_DECIDE;
                     end else begin
                        mem_we   = 1'b1;
                        count_in = count_ff + ndcm_pkg::CNT_W'(1);
                     end
                  end
                  ndcm_pkg::MODE_QUERY: begin
                     q_in       = req_depth;
                     last_in    = req_last_query;
                     refused_in = 1'b0;
                     best_in    = ndcm_pkg::SCAN_BOUND;
                     chosen_in  = 1'b0;
                     addr_in    = '0;
                     state_in   = (count_ff == '0) ? S_DECIDE : S_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            rd_vld_in = 1'b1;
            addr_in   = addr_ff + ndcm_pkg::IDX_W'(1);
            if (scan_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               found_in     = match;
               oi_in        = match ? {1'b0, bi_ff} : '1;
               oj_in        = match ? {1'b0, bj_ff} : '1;
               ok_in        = match ? {1'b0, bk_ff} : '1;
               refd_in      = refused_ff;
               lob_in       = last_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         tol_ff       <= ndcm_pkg::TOL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_vld_ff    <= rd_vld_in;
         tol_ff       <= tol_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      addr_ff    <= addr_in;
      q_ff       <= q_in;
      last_ff    <= last_in;
      refused_ff <= refused_in;
      best_ff    <= best_in;
      chosen_ff  <= chosen_in;
      bi_ff      <= bi_in;
      bj_ff      <= bj_in;
      bk_ff      <= bk_in;
      found_ff   <= found_in;
      oi_ff      <= oi_in;
      oj_ff      <= oj_in;
      ok_ff      <= ok_in;
      refd_ff    <= refd_in;
      lob_ff     <= lob_in;
   end

   // entry table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[count_ff[ndcm_pkg::IDX_W-1:0]] <= wr_entry;
      end
      rd_data_ff <= mem[addr_ff];
   end

   assign req_stall         = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = found_ff;
   assign rsp_out_i         = oi_ff;
   assign rsp_out_j         = oj_ff;
   assign rsp_out_k         = ok_ff;
   assign rsp_load_refused  = refd_ff;
   assign rsp_last_of_batch = lob_ff;

   assign csr_prdata = (csr_paddr == ndcm_pkg::CSR_TOL_ADDR) ? {1'b0, tol_ff} : '0;
   assign csr_pready = 1'b1;

endmodule

/* src/ndcm_checker.sv */
// Port-level checks for nearest_depth_cell_match, bound to the top level.
// Depends on ndcm_pkg and nearest_depth_cell_match_assert.svh.
`timescale 1ns / 1ps
`include "nearest_depth_cell_match_assert.svh"

module ndcm_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic [1:0]                          req_mode,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic                                rsp_found,
   input logic signed [ndcm_pkg::OUT_W-1:0]   rsp_out_i,
   input logic signed [ndcm_pkg::OUT_W-1:0]   rsp_out_j,
   input logic signed [ndcm_pkg::OUT_W-1:0]   rsp_out_k,
   input logic                                rsp_load_refused
);

   logic query_beat;
   logic all_ones;

   assign query_beat = req_valid && !req_stall && (req_mode == ndcm_pkg::MODE_QUERY);
   assign all_ones   = (&rsp_out_i) && (&rsp_out_j) && (&rsp_out_k);

   // held result beat stays up and unchanged
   `NDCM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable({rsp_found, rsp_out_i, rsp_out_j, rsp_out_k, rsp_load_refused}))

   // a query keeps the input side busy while it scans
   `NDCM_ASSERT_NEXT(a_query_busy, clock, reset, query_beat, req_stall)

   `NDCM_ASSERT_NOW(a_refused_shape, clock, reset, rsp_valid && rsp_load_refused, !rsp_found && all_ones)

   `NDCM_ASSERT_NOW(a_miss_shape, clock, reset, rsp_valid && !rsp_found, all_ones)

   `NDCM_ASSERT_NOW(a_hit_shape, clock, reset, rsp_valid && rsp_found, !rsp_load_refused && !rsp_out_i[ndcm_pkg::OUT_W-1])

endmodule

bind nearest_depth_cell_match ndcm_checker u_ndcm_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_mode         (req_mode),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_found        (rsp_found),
   .rsp_out_i        (rsp_out_i),
   .rsp_out_j        (rsp_out_j),
   .rsp_out_k        (rsp_out_k),
   .rsp_load_refused (rsp_load_refused)
);
